/* hw/rtl/mgcs_pkg.sv */
`timescale 1ns / 1ps

package mgcs_pkg;

  // Default number of grid levels the counter file is built for
  localparam int DEF_MAX_LEVELS = 16;

  // Action codes
  localparam logic [2:0] ACT_RELAX    = 3'd0;
  localparam logic [2:0] ACT_RESTRICT = 3'd1;
  localparam logic [2:0] ACT_INTERP   = 3'd2;
  localparam logic [2:0] ACT_DONE     = 3'd3;
  localparam logic [2:0] ACT_ABORT    = 3'd4;

  // Cycle phases
  localparam logic [1:0] PH_FINEST   = 2'd0;
  localparam logic [1:0] PH_DOWN     = 2'd1;
  localparam logic [1:0] PH_UP       = 2'd2;
  localparam logic [1:0] PH_COARSEST = 2'd3;

  // Input commands
  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LEVEL_COUNT     = 3'd0;
  localparam logic [2:0] REG_CYCLE_KIND      = 3'd1;
  localparam logic [2:0] REG_SWEEPS_FINEST   = 3'd2;
  localparam logic [2:0] REG_SWEEPS_DOWN     = 3'd3;
  localparam logic [2:0] REG_SWEEPS_UP       = 3'd4;
  localparam logic [2:0] REG_SWEEPS_COARSEST = 3'd5;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [4:0] RST_LEVEL_COUNT = 5'd1;
  localparam logic [1:0] RST_CYCLE_KIND  = 2'd1;
  localparam logic [3:0] RST_SWEEPS      = 4'd1;

  typedef struct packed {
    logic cmd;
    logic relax_failed;
  } in_req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] grid_level;
    logic [1:0] phase;
    logic [3:0] sweep_index;
  } out_req_t;

  // Sweep count for a phase
  function automatic logic [3:0] sweeps_for(input logic [1:0] ph,
                                            input logic [3:0] s_fin,
                                            input logic [3:0] s_dn,
                                            input logic [3:0] s_up,
                                            input logic [3:0] s_co);
    logic [3:0] s;
    case (ph)
      PH_FINEST: s = s_fin;
      PH_DOWN:   s = s_dn;
      PH_UP:     s = s_up;
      default:   s = s_co;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/multigrid_cycle_sequencer_core.sv */
`timescale 1ns / 1ps

// A request's action is registered into the output register, or into the skid
// register while the output side stalls. Throughput: one request per cycle while
// the skid is empty, which lets the input side accept one more action in a stall.
// Reset (synchronous, rst_n low): registers return to their defaults, visit
// counters clear to zero and the sequencer goes idle (answers done).
module multigrid_cycle_sequencer_core
  import mgcs_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  // action channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CMP_W = 8;

  // Configuration registers
  logic [4:0] lc_r;
  logic [1:0] ck_r;
  logic [3:0] sw_fin_r, sw_dn_r, sw_up_r, sw_co_r;

  // Sequencer state
  logic signed [2:0] cnt_r   [MAX_LEVELS];
  logic signed [2:0] cnt_nxt [MAX_LEVELS];
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [3:0]        sw_r, sw_nxt;
  logic [2:0]        last_r, last_nxt;

  // Output and skid stage
  out_req_t out_r, skid_r, res;
  logic     out_valid_r, skid_valid_r;

  // Decision datapath
  logic              in_acc, out_fire, is_start, cfg_wr;
  logic              go_enter, go_decide, descend;
  logic [LVL_W-1:0]  e_lvl, nxt_idx, fine_lvl;
  logic [1:0]        e_ph;
  logic signed [2:0] cur_c, nxt_c, c_dec, ck_s;
  logic [3:0]        sw_inc;
  logic [CMP_W-1:0]  n_use, lvl_p1;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r     <= RST_LEVEL_COUNT;
      ck_r     <= RST_CYCLE_KIND;
      sw_fin_r <= RST_SWEEPS;
      sw_dn_r  <= RST_SWEEPS;
      sw_up_r  <= RST_SWEEPS;
      sw_co_r  <= RST_SWEEPS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEVEL_COUNT:     lc_r     <= pwdata[4:0];
        REG_CYCLE_KIND:      ck_r     <= pwdata[1:0];
        REG_SWEEPS_FINEST:   sw_fin_r <= pwdata[3:0];
        REG_SWEEPS_DOWN:     sw_dn_r  <= pwdata[3:0];
        REG_SWEEPS_UP:       sw_up_r  <= pwdata[3:0];
        REG_SWEEPS_COARSEST: sw_co_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LEVEL_COUNT:     prdata = CFG_DATA_W'(lc_r);
      REG_CYCLE_KIND:      prdata = CFG_DATA_W'(ck_r);
      REG_SWEEPS_FINEST:   prdata = CFG_DATA_W'(sw_fin_r);
      REG_SWEEPS_DOWN:     prdata = CFG_DATA_W'(sw_dn_r);
      REG_SWEEPS_UP:       prdata = CFG_DATA_W'(sw_up_r);
      REG_SWEEPS_COARSEST: prdata = CFG_DATA_W'(sw_co_r);
      default:             prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ready  = ~skid_valid_r;
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r & out_ready;
  assign is_start  = (in_data.cmd == CMD_START);

  // Levels in use, clamped to 1..MAX_LEVELS
  always_comb begin
    if (lc_r == 5'd0) begin
      n_use = CMP_W'(1);
    end else if (CMP_W'(lc_r) > CMP_W'(MAX_LEVELS)) begin
      n_use = CMP_W'(MAX_LEVELS);
    end else begin
      n_use = CMP_W'(lc_r);
    end
  end

  // Level and counters the decision works on; a start sees fresh counters
  assign e_lvl    = is_start ? '0 : lvl_r;
  assign e_ph     = is_start ? PH_FINEST : ph_r;
  assign lvl_p1   = CMP_W'(e_lvl) + CMP_W'(1);
  assign nxt_idx  = (CMP_W'(e_lvl) == CMP_W'(MAX_LEVELS - 1)) ? '0 : LVL_W'(lvl_p1);
  assign fine_lvl = e_lvl - LVL_W'(1);
  assign ck_s     = signed'({1'b0, ck_r});
  assign cur_c    = is_start ? 3'sd1 : cnt_r[e_lvl];
  assign nxt_c    = is_start ? ck_s : cnt_r[nxt_idx];
  assign c_dec    = (cur_c != -3'sd4) ? (cur_c - 3'sd1) : cur_c;
  assign descend  = ~c_dec[2] && (lvl_p1 < n_use);
  assign sw_inc   = sw_r + 4'd1;

  // Next action and state
  always_comb begin
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    ph_nxt    = ph_r;
    sw_nxt    = sw_r;
    go_enter  = 1'b0;
    go_decide = 1'b0;
    res       = '{action: ACT_DONE, grid_level: '0, phase: '0, sweep_index: '0};

    if (is_start) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        cnt_nxt[k] = (k == 0) ? 3'sd1 : ck_s;
      end
      lvl_nxt  = '0;
      ph_nxt   = PH_FINEST;
      go_enter = 1'b1;
    end else begin
      case (last_r)
        ACT_RELAX: begin
          if (in_data.relax_failed) begin
            res.action = ACT_ABORT;
          end else begin
            sw_nxt = sw_inc;
            if (sw_inc != 4'd0 &&
                sw_inc < sweeps_for(ph_r, sw_fin_r, sw_dn_r, sw_up_r, sw_co_r)) begin
              res = '{action: ACT_RELAX, grid_level: 4'(lvl_r), phase: ph_r,
                      sweep_index: sw_inc};
            end else begin
              go_decide = 1'b1;
            end
          end
        end
        ACT_RESTRICT, ACT_INTERP: go_enter = 1'b1;
        default: res.action = ACT_DONE;
      endcase
    end

    // Start the sweeps at a level, or decide at once when there are none
    if (go_enter) begin
      sw_nxt = 4'd0;
      if (sweeps_for(e_ph, sw_fin_r, sw_dn_r, sw_up_r, sw_co_r) != 4'd0) begin
        res = '{action: ACT_RELAX, grid_level: 4'(e_lvl), phase: e_ph, sweep_index: 4'd0};
      end else begin
        go_decide = 1'b1;
      end
    end

    // Counter decision: descend, ascend or finish
    if (go_decide) begin
      cnt_nxt[e_lvl] = c_dec;
      if (descend) begin
        cnt_nxt[nxt_idx] = (nxt_c < ck_s) ? ck_s : nxt_c;
        lvl_nxt = nxt_idx;
        ph_nxt  = (lvl_p1 == n_use - CMP_W'(1)) ? PH_COARSEST : PH_DOWN;
        sw_nxt  = 4'd0;
        res     = '{action: ACT_RESTRICT, grid_level: 4'(e_lvl), phase: '0,
                    sweep_index: '0};
      end else if (e_lvl != '0) begin
        lvl_nxt = fine_lvl;
        ph_nxt  = (fine_lvl == '0) ? PH_FINEST : PH_UP;
        sw_nxt  = 4'd0;
        res     = '{action: ACT_INTERP, grid_level: 4'(fine_lvl), phase: '0,
                    sweep_index: '0};
      end else begin
        res = '{action: ACT_DONE, grid_level: '0, phase: '0, sweep_index: '0};
      end
    end

    last_nxt = res.action;
  end

  // Sequencer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        cnt_r[k] <= 3'sd0;
      end
      lvl_r  <= '0;
      ph_r   <= PH_FINEST;
      sw_r   <= 4'd0;
      last_r <= ACT_DONE;
    end else if (in_acc) begin
      cnt_r  <= cnt_nxt;
      lvl_r  <= lvl_nxt;
      ph_r   <= ph_nxt;
      sw_r   <= sw_nxt;
      last_r <= last_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
